>>> hdl/mtpa_pkg.sv
// mtpa_pkg: widths, pipeline depths and the side-band type shared by the
// d-axis current reference pipeline. No dependencies.
package mtpa_pkg;

  localparam int W        = 24;                // register and current width
  localparam int PROD_W   = 2 * W;             // 24x24 product
  localparam int RAD_W    = 98;                // radicand, padded to even width
  localparam int ROOT_W   = RAD_W / 2;         // root bits, one per sqrt stage
  localparam int REM_W    = ROOT_W + 2;        // sqrt remainder
  localparam int QUO_W    = W + 1;             // quotient bits, one per div stage
  localparam int DIV_W    = W + 1;             // divisor 2*(lq-ld)
  localparam int NUM_W    = ROOT_W;            // dividend s - flux*2^16
  localparam int FRONT_LAT = 4;
  localparam int LATENCY  = FRONT_LAT + ROOT_W + QUO_W + 1;

  localparam logic [1:0] REG_FLUX = 2'd0;
  localparam logic [1:0] REG_LD   = 2'd1;
  localparam logic [1:0] REG_LQ   = 2'd2;

  localparam logic [W:0] MAG_SAT = (W+1)'(1) << (W - 1);

  typedef struct packed {
    logic         pos;   // lq above ld
    logic [W-1:0] dd;    // lq - ld
    logic [W-1:0] flux;
  } side_t;

endpackage

>>> hdl/mtpa_front.sv
// mtpa_front: magnitude, products and radicand f^2*2^32 + 4*(d*q)^2.
// Four register stages; depends on mtpa_pkg.
module mtpa_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [mtpa_pkg::W-1:0]        q_current,
  input  logic [mtpa_pkg::W-1:0]        flux,
  input  logic [mtpa_pkg::W-1:0]        ld,
  input  logic [mtpa_pkg::W-1:0]        lq,
  output logic                          rad_vld,
  output logic [mtpa_pkg::RAD_W-1:0]    rad,
  output mtpa_pkg::side_t               rad_side
);

  localparam int W = mtpa_pkg::W;
  localparam int P = mtpa_pkg::PROD_W;

  logic [3:0]   vld_r;
  mtpa_pkg::side_t side1_r, side2_r, side3_r, side4_r;
  logic [W-1:0] qmag1_r;
  logic [P-1:0] dq2_r, f2_2_r, f2_3_r;
  logic [P-1:0] hh3_r, hl3_r, ll3_r;
  logic [mtpa_pkg::RAD_W-1:0] rad4_r;
  logic [W-1:0] qmag_nxt;
  logic [mtpa_pkg::RAD_W-1:0] rad_nxt;

  // abs of a 24-bit code; the most negative value fits unsigned
  assign qmag_nxt = q_current[W-1] ? (~q_current + W'(1)) : q_current;

  always_comb begin
    rad_nxt = ({50'b0, f2_3_r} << 32)
            + ({50'b0, hh3_r} << 50)
            + ({50'b0, hl3_r} << 27)
            + ({50'b0, ll3_r} << 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
    side1_r.pos  <= lq > ld;
    side1_r.dd   <= lq - ld;
    side1_r.flux <= flux;
    qmag1_r      <= qmag_nxt;
    side2_r      <= side1_r;
    dq2_r        <= side1_r.dd * qmag1_r;
    f2_2_r       <= side1_r.flux * side1_r.flux;
    side3_r      <= side2_r;
    f2_3_r       <= f2_2_r;
    // dq split into 24-bit halves to keep each multiplier narrow
    hh3_r        <= dq2_r[P-1:W] * dq2_r[P-1:W];
    hl3_r        <= dq2_r[P-1:W] * dq2_r[W-1:0];
    ll3_r        <= dq2_r[W-1:0] * dq2_r[W-1:0];
    side4_r      <= side3_r;
    rad4_r       <= rad_nxt;
  end

  assign rad_vld  = vld_r[3];
  assign rad      = rad4_r;
  assign rad_side = side4_r;

endmodule

>>> hdl/mtpa_sqrt.sv
// mtpa_sqrt: pipelined restoring integer square root, one root bit per stage.
// Depends on mtpa_pkg.
module mtpa_sqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  logic [mtpa_pkg::RAD_W-1:0]      rad,
  input  mtpa_pkg::side_t                 in_side,
  output logic                            out_vld,
  output logic [mtpa_pkg::ROOT_W-1:0]     root,
  output mtpa_pkg::side_t                 out_side
);

  localparam int N  = mtpa_pkg::ROOT_W;
  localparam int RW = mtpa_pkg::REM_W;
  localparam int XW = mtpa_pkg::RAD_W;

  logic [N-1:0]    vld_r;
  logic [RW-1:0]   rem_r  [N];
  logic [N-1:0]    root_r [N];
  logic [XW-1:0]   x_r    [N];
  mtpa_pkg::side_t side_r [N];

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_stage
      logic            vld_in;
      logic [RW-1:0]   rem_in;
      logic [N-1:0]    root_in;
      logic [XW-1:0]   x_in;
      mtpa_pkg::side_t side_in;
      logic [RW+1:0]   trial;
      logic [RW+1:0]   sub;
      logic            take;

      if (i == 0) begin : g_first
        assign vld_in  = in_vld;
        assign rem_in  = '0;
        assign root_in = '0;
        assign x_in    = rad;
        assign side_in = in_side;
      end else begin : g_next
        assign vld_in  = vld_r[i-1];
        assign rem_in  = rem_r[i-1];
        assign root_in = root_r[i-1];
        assign x_in    = x_r[i-1];
        assign side_in = side_r[i-1];
      end

      assign trial = {rem_in, x_in[XW-1:XW-2]};
      assign sub   = {2'b00, root_in, 2'b01};
      assign take  = trial >= sub;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else begin
          vld_r[i] <= vld_in;
        end
        rem_r[i]  <= take ? RW'(trial - sub) : trial[RW-1:0];
        root_r[i] <= {root_in[N-2:0], take};
        x_r[i]    <= {x_in[XW-3:0], 2'b00};
        side_r[i] <= side_in;
      end
    end
  endgenerate

  assign out_vld  = vld_r[N-1];
  assign root     = root_r[N-1];
  assign out_side = side_r[N-1];

endmodule

>>> hdl/mtpa_div.sv
// mtpa_div: pipelined restoring divider (s - flux*2^16) / (2*d), one quotient
// bit per stage, saturated magnitude out. Depends on mtpa_pkg.
module mtpa_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  logic [mtpa_pkg::ROOT_W-1:0]     root,
  input  mtpa_pkg::side_t                 in_side,
  output logic                            out_vld,
  output logic [mtpa_pkg::W:0]            mag
);

  localparam int N  = mtpa_pkg::QUO_W;
  localparam int DW = mtpa_pkg::DIV_W;
  localparam int NW = mtpa_pkg::NUM_W;
  localparam int W  = mtpa_pkg::W;

  logic [NW-1:0] base;
  logic [NW-1:0] num0;

  assign base = {9'b0, in_side.flux, 16'b0};
  assign num0 = (in_side.pos && root > base) ? (root - base) : '0;

  logic [N-1:0]  vld_r;
  logic [DW-1:0] rem_r  [N];
  logic [NW-1:0] num_r  [N];
  logic [N-1:0]  quo_r  [N];
  logic [DW-1:0] dvs_r  [N];
  logic          pos_r  [N];

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_stage
      logic          vld_in;
      logic [DW-1:0] rem_in;
      logic [NW-1:0] num_in;
      logic [N-1:0]  quo_in;
      logic [DW-1:0] dvs_in;
      logic          pos_in;
      logic [DW:0]   trial;
      logic          take;

      if (i == 0) begin : g_first
        assign vld_in = in_vld;
        // high part is below the divisor since the quotient fits QUO_W bits
        assign rem_in = {1'b0, num0[NW-1:N]};
        assign num_in = num0;
        assign quo_in = '0;
        assign dvs_in = {in_side.dd, 1'b0};
        assign pos_in = in_side.pos;
      end else begin : g_next
        assign vld_in = vld_r[i-1];
        assign rem_in = rem_r[i-1];
        assign num_in = num_r[i-1];
        assign quo_in = quo_r[i-1];
        assign dvs_in = dvs_r[i-1];
        assign pos_in = pos_r[i-1];
      end

      assign trial = {rem_in, num_in[N-1-i]};
      assign take  = trial >= {1'b0, dvs_in};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else begin
          vld_r[i] <= vld_in;
        end
        rem_r[i] <= take ? DW'(trial - {1'b0, dvs_in}) : trial[DW-1:0];
        num_r[i] <= num_in;
        quo_r[i] <= {quo_in[N-2:0], take};
        dvs_r[i] <= dvs_in;
        pos_r[i] <= pos_in;
      end
    end
  endgenerate

  logic [W:0] quo;
  assign quo = quo_r[N-1];

  assign out_vld = vld_r[N-1];
  assign mag = !pos_r[N-1] ? '0 :
               (quo > mtpa_pkg::MAG_SAT) ? mtpa_pkg::MAG_SAT : quo;

endmodule

>>> hdl/mtpa_d_axis_current_top.sv
// mtpa_d_axis_current_top: MTPA d-axis current reference, fully pipelined.
// Depends on mtpa_pkg, mtpa_front, mtpa_sqrt, mtpa_div.
//
//  channel   ports                              handshake
//  input     in_q_current                       start && !busy
//  result    out_d_current_ref                  out_valid, one cycle
//  config    cfg_we, cfg_index, cfg_data        cfg_we
//
// One transaction per cycle; each result passes through 4 front stages,
// 49 square-root stages (one root bit each), 25 divider stages (one quotient
// bit each) and the output register.
// Synchronous reset clears all valid bits; busy is high only during reset.
// The receiver cannot stall, so the pipeline advances every cycle.
module mtpa_d_axis_current_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [mtpa_pkg::W-1:0]     in_q_current,
  output logic                       out_valid,
  output logic [mtpa_pkg::W-1:0]     out_d_current_ref,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [mtpa_pkg::W-1:0]     cfg_data
);

  localparam int W = mtpa_pkg::W;

  logic [W-1:0] flux_r, ld_r, lq_r;
  logic         accept;

  assign busy   = ~rst_n;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flux_r <= '0;
      ld_r   <= '0;
      lq_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mtpa_pkg::REG_FLUX: flux_r <= cfg_data;
        mtpa_pkg::REG_LD:   ld_r   <= cfg_data;
        mtpa_pkg::REG_LQ:   lq_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                          rad_vld;
  logic [mtpa_pkg::RAD_W-1:0]    rad;
  mtpa_pkg::side_t               rad_side;
  logic                          sq_vld;
  logic [mtpa_pkg::ROOT_W-1:0]   sq_root;
  mtpa_pkg::side_t               sq_side;
  logic                          dv_vld;
  logic [W:0]                    dv_mag;

  mtpa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (accept),
    .q_current (in_q_current),
    .flux      (flux_r),
    .ld        (ld_r),
    .lq        (lq_r),
    .rad_vld   (rad_vld),
    .rad       (rad),
    .rad_side  (rad_side)
  );

  mtpa_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (rad_vld),
    .rad      (rad),
    .in_side  (rad_side),
    .out_vld  (sq_vld),
    .root     (sq_root),
    .out_side (sq_side)
  );

  mtpa_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (sq_vld),
    .root    (sq_root),
    .in_side (sq_side),
    .out_vld (dv_vld),
    .mag     (dv_mag)
  );

  logic         out_valid_r;
  logic [W-1:0] out_ref_r;
  logic [W:0]   neg_mag;

  assign neg_mag = (W+1)'(0) - dv_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld;
    end
    out_ref_r <= neg_mag[W-1:0];
  end

  assign out_valid         = out_valid_r;
  assign out_d_current_ref = out_ref_r;

  // every result traces back to an accepted transaction
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, mtpa_pkg::LATENCY))
    else $error("result without matching transaction");

  // the reference never goes positive
  a_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_d_current_ref[W-1] || out_d_current_ref == '0))
    else $error("positive d-axis reference");

endmodule
